// ===== rtl/core/g2e_pkg.sv =====
// Shared constants, table builders and types for the geodetic to ECEF core.
package g2e_pkg;

  localparam logic [63:0] ONE_Q61 = 64'd1 << 61;
  localparam int MAX_STAGES = 46;

  localparam logic [32:0] AXIS_RESET = 33'd6378137000;
  localparam logic [28:0] ECC_RESET = 29'd28752143;

  localparam logic REG_AXIS = 1'b0;
  localparam logic REG_ECC = 1'b1;

  typedef logic [63:0] atan_tab_t [0:MAX_STAGES-1];

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      q = {q[62:0], 1'b0};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic done;
    t = udiv(ONE_Q61, n);
    sum = t;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        t = udiv(t, n * n);
        if (t == 64'd0) begin
          done = 1'b1;
        end else begin
          term = udiv(t, 64'(2 * k + 1));
          if (k[0]) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] pi_q61();
    return 64'd16 * atan_inv(64'd5) - 64'd4 * atan_inv(64'd239);
  endfunction

  function automatic logic [63:0] atan_q61(input int i);
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] term;
    logic done;
    if (i == 0) return pi_q61() >> 2;
    t = ONE_Q61 >> i;
    sum = t;
    done = 1'b0;
    if (2 * i < 64) begin
      for (int k = 1; k < 64; k++) begin
        if (!done) begin
          t = t >> (2 * i);
          if (t == 64'd0) begin
            done = 1'b1;
          end else begin
            term = udiv(t, 64'(2 * k + 1));
            if (k[0]) sum = sum - term;
            else sum = sum + term;
          end
        end
      end
    end
    return sum;
  endfunction

  function automatic atan_tab_t make_atan_tab();
    atan_tab_t tab;
    for (int i = 0; i < MAX_STAGES; i++) tab[i] = atan_q61(i);
    return tab;
  endfunction

  function automatic logic [63:0] cordic_gain(input int stages);
    logic [63:0] p;
    logic [63:0] root;
    logic [63:0] cand;
    logic [127:0] v;
    logic [127:0] sq;
    logic [127:0] num;
    logic [64:0] rem;
    logic [63:0] q;
    p = ONE_Q61;
    for (int i = 0; i < stages; i++) begin
      if (2 * i < 64) p = p + (p >> (2 * i));
    end
    v = {64'd0, p} << 61;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= v) root = cand;
    end
    num = 128'd1 << 122;
    rem = '0;
    q = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      q = {q[62:0], 1'b0};
      if (rem >= {1'b0, root}) begin
        rem = rem - {1'b0, root};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== rtl/core/g2e_cordic.sv =====
// Pipelined rotation CORDIC with quadrant fix-up, one stage per iteration.
module g2e_cordic #(
  parameter int TRIG_STAGES = 30
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [63:0] z_in,
  input  logic        [1:0]  q_in,
  output logic signed [63:0] sin_out,
  output logic signed [63:0] cos_out
);

  localparam logic [63:0] GAIN = g2e_pkg::cordic_gain(TRIG_STAGES);
  localparam g2e_pkg::atan_tab_t ATAN = g2e_pkg::make_atan_tab();

  logic signed [63:0] x [0:TRIG_STAGES-1];
  logic signed [63:0] y [0:TRIG_STAGES-1];
  logic signed [63:0] z [0:TRIG_STAGES-1];
  logic        [1:0]  q [0:TRIG_STAGES-1];
  logic signed [63:0] x_src [0:TRIG_STAGES-1];
  logic signed [63:0] y_src [0:TRIG_STAGES-1];
  logic signed [63:0] z_src [0:TRIG_STAGES-1];
  logic        [1:0]  q_src [0:TRIG_STAGES-1];
  logic signed [63:0] x_next [0:TRIG_STAGES-1];
  logic signed [63:0] y_next [0:TRIG_STAGES-1];
  logic signed [63:0] z_next [0:TRIG_STAGES-1];

  always_comb begin
    x_src[0] = GAIN;
    y_src[0] = '0;
    z_src[0] = z_in;
    q_src[0] = q_in;
    for (int i = 1; i < TRIG_STAGES; i++) begin
      x_src[i] = x[i-1];
      y_src[i] = y[i-1];
      z_src[i] = z[i-1];
      q_src[i] = q[i-1];
    end
    for (int i = 0; i < TRIG_STAGES; i++) begin
      if (z_src[i][63]) begin
        x_next[i] = x_src[i] + (y_src[i] >>> i);
        y_next[i] = y_src[i] - (x_src[i] >>> i);
        z_next[i] = z_src[i] + ATAN[i];
      end else begin
        x_next[i] = x_src[i] - (y_src[i] >>> i);
        y_next[i] = y_src[i] + (x_src[i] >>> i);
        z_next[i] = z_src[i] - ATAN[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < TRIG_STAGES; i++) begin
        x[i] <= x_next[i];
        y[i] <= y_next[i];
        z[i] <= z_next[i];
        q[i] <= q_src[i];
      end
      case (q[TRIG_STAGES-1])
        2'd0: begin
          cos_out <= x[TRIG_STAGES-1];
          sin_out <= y[TRIG_STAGES-1];
        end
        2'd1: begin
          cos_out <= -y[TRIG_STAGES-1];
          sin_out <= x[TRIG_STAGES-1];
        end
        2'd2: begin
          cos_out <= -x[TRIG_STAGES-1];
          sin_out <= -y[TRIG_STAGES-1];
        end
        default: begin
          cos_out <= y[TRIG_STAGES-1];
          sin_out <= -x[TRIG_STAGES-1];
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/geodetic_to_ecef_core.sv =====
// Geodetic to ECEF conversion core: trig, prime-vertical radius and products.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_ready     latitude, longitude, height_mm
//   result    out        out_valid / out_ready   x_mm, y_mm, z_mm
//   config    in         wr_en                   wr_index, wr_data
//
// One item enters per cycle while the output register is not stalled.
// The pipeline runs through the CORDIC stages, the 61-step square root and the 58-step divider.
// All stages advance together; a stalled output register holds the whole pipeline.
// Reset clears valid bits and loads the WGS84 axis and eccentricity.
module geodetic_to_ecef_core #(
  parameter int ANGLE_BITS  = 32,
  parameter int TRIG_STAGES = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic signed [27:0] height_mm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [33:0] x_mm,
  output logic signed [33:0] y_mm,
  output logic signed [33:0] z_mm,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic        [32:0] wr_data
);

  localparam int TR       = TRIG_STAGES + 4;
  localparam int LAT      = TR + 131;
  localparam int HD       = TR + 125;
  localparam int DL_LAT   = 126;
  localparam int DL_LON   = 128;
  localparam int SQ_STEPS = 61;
  localparam int DV_STEPS = 58;

  localparam logic [63:0] PHASE_MASK = ~((64'd1 << (64 - ANGLE_BITS)) - 64'd1);
  localparam logic [63:0] PI = g2e_pkg::pi_q61();
  localparam logic [63:0] QUARTER = 64'd1 << 62;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;
  localparam logic [63:0] HALF_MM = 64'd1 << 23;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< 33) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -(64'sd1 <<< 33);

  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } pp_t;

  function automatic pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.p00 = 64'(a[31:0]) * 64'(b[31:0]);
    p.p01 = 64'(a[31:0]) * 64'(b[63:32]);
    p.p10 = 64'(a[63:32]) * 64'(b[31:0]);
    p.p11 = 64'(a[63:32]) * 64'(b[63:32]);
    return p;
  endfunction

  function automatic logic [127:0] mul_join(input pp_t p);
    return {p.p11, 64'd0} + {32'd0, p.p10, 32'd0} + {32'd0, p.p01, 32'd0} + {64'd0, p.p00};
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] u);
    return u[63] ? -u : u;
  endfunction

  function automatic logic [63:0] sprod61(input pp_t p, input logic neg);
    logic [127:0] full;
    logic [63:0] m;
    full = mul_join(p);
    m = full[124:61];
    return neg ? -m : m;
  endfunction

  function automatic logic [33:0] round_sat(input logic [63:0] v);
    logic [63:0] s;
    logic signed [63:0] r;
    s = v + HALF_MM;
    r = $signed(s) >>> 24;
    if (r > SAT_HI) return SAT_HI[33:0];
    if (r < SAT_LO) return SAT_LO[33:0];
    return r[33:0];
  endfunction

  logic [32:0] semi_major_axis_mm;
  logic [28:0] eccentricity_squared;
  logic [LAT:1] vld;
  logic adv;

  assign adv = !vld[LAT] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_major_axis_mm <= g2e_pkg::AXIS_RESET;
      eccentricity_squared <= g2e_pkg::ECC_RESET;
    end else if (wr_en) begin
      case (wr_index)
        g2e_pkg::REG_AXIS: semi_major_axis_mm <= wr_data;
        g2e_pkg::REG_ECC: eccentricity_squared <= wr_data[28:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // angle reduction and radian scaling, lane 0 latitude, lane 1 longitude
  logic [31:0] ang [0:1];
  logic [63:0] ph [0:1];
  logic [63:0] qs [0:1];
  logic [63:0] rr [0:1];
  logic [1:0]  a1_q [0:1];
  logic        a1_neg [0:1];
  logic [63:0] a1_mr [0:1];
  pp_t         a2_pp [0:1];
  logic        a2_neg [0:1];
  logic [1:0]  a2_q [0:1];
  logic signed [63:0] a3_z [0:1];
  logic [1:0]  a3_q [0:1];
  logic [127:0] a3_full [0:1];
  logic signed [63:0] sn [0:1];
  logic signed [63:0] cs [0:1];

  assign ang[0] = latitude;
  assign ang[1] = longitude;

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      ph[g] = {ang[g], 32'd0} & PHASE_MASK;
      qs[g] = ph[g] + QUARTER;
      rr[g] = ph[g] - {qs[g][63:62], 62'd0};
      a3_full[g] = mul_join(a2_pp[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int g = 0; g < 2; g++) begin
        a1_q[g] <= qs[g][63:62];
        a1_neg[g] <= rr[g][63];
        a1_mr[g] <= mag(rr[g]);
        a2_pp[g] <= mul_parts(a1_mr[g], PI);
        a2_neg[g] <= a1_neg[g];
        a2_q[g] <= a1_q[g];
        a3_z[g] <= a2_neg[g] ? -a3_full[g][127:64] : a3_full[g][127:64];
        a3_q[g] <= a2_q[g];
      end
    end
  end

  g2e_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_lat (
    .clk(clk), .adv(adv), .z_in(a3_z[0]), .q_in(a3_q[0]), .sin_out(sn[0]), .cos_out(cs[0])
  );

  g2e_cordic #(.TRIG_STAGES(TRIG_STAGES)) u_cordic_lon (
    .clk(clk), .adv(adv), .z_in(a3_z[1]), .q_in(a3_q[1]), .sin_out(sn[1]), .cos_out(cs[1])
  );

  // delay lines to line up height and trig values with the radius
  logic signed [27:0] h_dl [1:HD];
  logic [63:0] slat_dl [1:DL_LAT];
  logic [63:0] clat_dl [1:DL_LAT];
  logic [63:0] slon_dl [1:DL_LON];
  logic [63:0] clon_dl [1:DL_LON];

  always_ff @(posedge clk) begin
    if (adv) begin
      h_dl[1] <= height_mm;
      for (int k = 2; k <= HD; k++) h_dl[k] <= h_dl[k-1];
      slat_dl[1] <= sn[0];
      clat_dl[1] <= cs[0];
      for (int k = 2; k <= DL_LAT; k++) begin
        slat_dl[k] <= slat_dl[k-1];
        clat_dl[k] <= clat_dl[k-1];
      end
      slon_dl[1] <= sn[1];
      clon_dl[1] <= cs[1];
      for (int k = 2; k <= DL_LON; k++) begin
        slon_dl[k] <= slon_dl[k-1];
        clon_dl[k] <= clon_dl[k-1];
      end
    end
  end

  // 1 - e2 sin^2
  pp_t b1_pp;
  logic [63:0] b2_s2;
  pp_t b3_pp;
  logic [127:0] b2_full;
  logic [127:0] b4_full;
  logic [63:0] b4_wv;

  assign b2_full = mul_join(b1_pp);
  assign b4_full = mul_join(b3_pp);
  assign b4_wv = ONE_Q60 - b4_full[95:32];

  // square root, one result bit per stage
  logic [60:0] sq_w [0:SQ_STEPS];
  logic [61:0] sq_rem [0:SQ_STEPS];
  logic [60:0] sq_root [0:SQ_STEPS];
  logic [61:0] sq_rem_next [1:SQ_STEPS];
  logic [60:0] sq_root_next [1:SQ_STEPS];

  always_comb begin
    logic [121:0] vv;
    logic [63:0] cat;
    logic [62:0] trial;
    vv = '0;
    cat = '0;
    trial = '0;
    for (int s = 1; s <= SQ_STEPS; s++) begin
      vv = {1'b0, sq_w[s-1], 60'd0};
      cat = {sq_rem[s-1], vv[2 * (SQ_STEPS - s) +: 2]};
      trial = {sq_root[s-1][60:0], 2'b01};
      if (cat >= {1'b0, trial}) begin
        sq_rem_next[s] = 62'(cat - {1'b0, trial});
        sq_root_next[s] = {sq_root[s-1][59:0], 1'b1};
      end else begin
        sq_rem_next[s] = cat[61:0];
        sq_root_next[s] = {sq_root[s-1][59:0], 1'b0};
      end
    end
  end

  // restoring divide a * 2^84 / root, one quotient bit per stage
  logic [60:0] dv_rem [0:DV_STEPS];
  logic [60:0] dv_d [0:DV_STEPS];
  logic [57:0] dv_q [0:DV_STEPS];
  logic [60:0] dv_rem_next [1:DV_STEPS];
  logic [57:0] dv_q_next [1:DV_STEPS];

  always_comb begin
    logic [61:0] t;
    t = '0;
    for (int j = 1; j <= DV_STEPS; j++) begin
      t = {dv_rem[j-1], 1'b0};
      if (t >= {1'b0, dv_d[j-1]}) begin
        dv_rem_next[j] = 61'(t - {1'b0, dv_d[j-1]});
        dv_q_next[j] = {dv_q[j-1][56:0], 1'b1};
      end else begin
        dv_rem_next[j] = t[60:0];
        dv_q_next[j] = {dv_q[j-1][56:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_pp <= mul_parts(mag(sn[0]), mag(sn[0]));
      b2_s2 <= b2_full[125:62];
      b3_pp <= mul_parts({35'd0, eccentricity_squared}, b2_s2);
      sq_w[0] <= b4_wv[60:0];
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      for (int s = 1; s <= SQ_STEPS; s++) begin
        sq_w[s] <= sq_w[s-1];
        sq_rem[s] <= sq_rem_next[s];
        sq_root[s] <= sq_root_next[s];
      end
      dv_rem[0] <= {2'b00, semi_major_axis_mm, 26'd0};
      dv_d[0] <= sq_root[SQ_STEPS];
      dv_q[0] <= '0;
      for (int j = 1; j <= DV_STEPS; j++) begin
        dv_rem[j] <= dv_rem_next[j];
        dv_d[j] <= dv_d[j-1];
        dv_q[j] <= dv_q_next[j];
      end
    end
  end

  // radius combination and final products
  pp_t c1_pp;
  logic [63:0] c1_n;
  logic [63:0] c2_nh;
  logic [63:0] c2_zt;
  pp_t c3_pp_x;
  pp_t c3_pp_z;
  logic c3_neg_x;
  logic c3_neg_z;
  logic [63:0] c4_nc;
  logic [63:0] c4_zz;
  pp_t c5_pp_x;
  pp_t c5_pp_y;
  logic c5_neg_x;
  logic c5_neg_y;
  logic [63:0] c5_zz;
  logic [63:0] c6_x;
  logic [63:0] c6_y;
  logic [63:0] c6_z;
  logic [127:0] c2_full;
  logic [63:0] c2_hq;

  assign c2_full = mul_join(c1_pp);
  assign c2_hq = {{12{h_dl[HD][27]}}, h_dl[HD], 24'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_pp <= mul_parts({6'd0, dv_q[DV_STEPS]}, {35'd0, eccentricity_squared});
      c1_n <= {6'd0, dv_q[DV_STEPS]};
      c2_nh <= c1_n + c2_hq;
      c2_zt <= c1_n - c2_full[95:32] + c2_hq;
      c3_pp_x <= mul_parts(mag(c2_nh), mag(clat_dl[DL_LAT]));
      c3_neg_x <= c2_nh[63] ^ clat_dl[DL_LAT][63];
      c3_pp_z <= mul_parts(mag(c2_zt), mag(slat_dl[DL_LAT]));
      c3_neg_z <= c2_zt[63] ^ slat_dl[DL_LAT][63];
      c4_nc <= sprod61(c3_pp_x, c3_neg_x);
      c4_zz <= sprod61(c3_pp_z, c3_neg_z);
      c5_pp_x <= mul_parts(mag(c4_nc), mag(clon_dl[DL_LON]));
      c5_neg_x <= c4_nc[63] ^ clon_dl[DL_LON][63];
      c5_pp_y <= mul_parts(mag(c4_nc), mag(slon_dl[DL_LON]));
      c5_neg_y <= c4_nc[63] ^ slon_dl[DL_LON][63];
      c5_zz <= c4_zz;
      c6_x <= sprod61(c5_pp_x, c5_neg_x);
      c6_y <= sprod61(c5_pp_y, c5_neg_y);
      c6_z <= c5_zz;
      x_mm <= round_sat(c6_x);
      y_mm <= round_sat(c6_y);
      z_mm <= round_sat(c6_z);
    end
  end

endmodule

// ===== rtl/core/g2e_checker.sv =====
// Port-level assertions for the geodetic to ECEF core, bound to the top level.
module g2e_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] latitude,
  input logic signed [31:0] longitude,
  input logic signed [27:0] height_mm,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [33:0] x_mm,
  input logic signed [33:0] y_mm,
  input logic signed [33:0] z_mm,
  input logic               wr_en,
  input logic               wr_index,
  input logic        [32:0] wr_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(x_mm) && $stable(y_mm) && $stable(z_mm))
    else $error("stalled result item changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output register");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item valid after reset");

endmodule

bind geodetic_to_ecef_core g2e_checker u_g2e_checker (.*);

// ===== test/tb_geodetic_to_ecef_core.sv =====
// Testbench for geodetic_to_ecef_core: directed and randomized stimulus checked against a bit-exact predictor.
`timescale 1ns / 100ps

module tb_geodetic_to_ecef_core;

  localparam int STAGES = 30;
  localparam int LATENCY = STAGES + 135;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lon;
    logic [27:0] hgt;
  } position_t;

  typedef struct packed {
    logic [33:0] x;
    logic [33:0] y;
    logic [33:0] z;
  } ecef_t;

  typedef struct packed {
    logic [63:0] s;
    logic [63:0] c;
  } trig_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] latitude;
  logic signed [31:0] longitude;
  logic signed [27:0] height_mm;
  logic out_valid;
  logic out_ready;
  logic signed [33:0] x_mm;
  logic signed [33:0] y_mm;
  logic signed [33:0] z_mm;
  logic wr_en;
  logic wr_index;
  logic [32:0] wr_data;

  geodetic_to_ecef_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .latitude(latitude), .longitude(longitude), .height_mm(height_mm),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  position_t pending_positions[$];
  ecef_t expected_ecef[$];

  logic [63:0] atan_q61_tab [0:STAGES-1];
  logic [63:0] pi_val;
  logic [63:0] gain_val;
  logic [32:0] axis_mm;
  logic [28:0] ecc_sq;

  logic in_taken;
  logic hold_send;
  logic steady;
  logic stall_req;
  int stall_left;
  int errors;
  int items_in;
  int results_out;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int sh);
    logic [127:0] prod;
    logic [63:0] m;
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    m = 64'(prod >> sh);
    return (a[63] != b[63]) ? -m : m;
  endfunction

  function automatic logic [63:0] root128(input logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] series_atan_inv(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] sum;
    t = g2e_pkg::ONE_Q61 / n;
    sum = t;
    for (int k = 1; k < 64; k++) begin
      t = t / (n * n);
      if (t == 0) break;
      if (k % 2 == 1) sum = sum - t / (2 * k + 1);
      else sum = sum + t / (2 * k + 1);
    end
    return sum;
  endfunction

  function automatic trig_t sin_cos(input logic [31:0] ang);
    logic [63:0] ph;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] dx;
    logic [63:0] dy;
    trig_t t;
    ph = {ang, 32'd0};
    q = (ph + (64'd1 << 62)) >> 62;
    r = ph - (q << 62);
    z = mul_shift(r, pi_val, 64);
    x = gain_val;
    y = '0;
    for (int i = 0; i < STAGES; i++) begin
      dx = $signed(y) >>> i;
      dy = $signed(x) >>> i;
      if (z[63]) begin
        x = x + dx; y = y - dy; z = z + atan_q61_tab[i];
      end else begin
        x = x - dx; y = y + dy; z = z - atan_q61_tab[i];
      end
    end
    case (q[1:0])
      2'd0: begin t.c = x; t.s = y; end
      2'd1: begin t.c = -y; t.s = x; end
      2'd2: begin t.c = -x; t.s = -y; end
      default: begin t.c = y; t.s = -x; end
    endcase
    return t;
  endfunction

  function automatic logic [33:0] round_clamp(input logic [63:0] v);
    logic signed [63:0] r;
    r = $signed(v + (64'd1 << 23)) >>> 24;
    if (r > 64'sd8589934591) r = 64'sd8589934591;
    if (r < -64'sd8589934592) r = -64'sd8589934592;
    return r[33:0];
  endfunction

  function automatic ecef_t convert_position(input position_t p);
    trig_t tl;
    trig_t tn;
    logic [63:0] h;
    logic [63:0] s2;
    logic [63:0] w;
    logic [63:0] root;
    logic [63:0] n;
    logic [63:0] nh;
    logic [63:0] zt;
    logic [63:0] nc;
    logic [127:0] prod;
    ecef_t e;
    h = {{36{p.hgt[27]}}, p.hgt};
    tl = sin_cos(p.lat);
    tn = sin_cos(p.lon);
    prod = {64'd0, abs64(tl.s)} * {64'd0, abs64(tl.s)};
    s2 = 64'(prod >> 62);
    prod = {99'd0, ecc_sq} * {64'd0, s2};
    w = (64'd1 << 60) - 64'(prod >> 32);
    root = root128({64'd0, w} << 60);
    n = 64'(({95'd0, axis_mm} << 84) / {64'd0, root});
    nh = n + (h << 24);
    prod = {64'd0, n} * {99'd0, ecc_sq};
    zt = n - 64'(prod >> 32) + (h << 24);
    nc = mul_shift(nh, tl.c, 61);
    e.x = round_clamp(mul_shift(nc, tn.c, 61));
    e.y = round_clamp(mul_shift(nc, tn.s, 61));
    e.z = round_clamp(mul_shift(zt, tl.s, 61));
    return e;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (!rst && !hold_send && pending_positions.size() > 0 &&
          (steady || $urandom_range(99) >= 17)) begin
        in_valid <= 1'b1;
        {latitude, longitude, height_mm} <= pending_positions.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (stall_req && stall_left == 0) begin
      stall_left <= 600;
      out_ready <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 1) stall_left <= -1;
      out_ready <= steady || $urandom_range(99) >= 17;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    ecef_t exp_e;
    in_taken <= in_valid && in_ready;
    if (rst) begin
      axis_mm <= g2e_pkg::AXIS_RESET;
      ecc_sq <= g2e_pkg::ECC_RESET;
    end else begin
      if (wr_en) begin
        if (wr_index == g2e_pkg::REG_AXIS) axis_mm <= wr_data;
        else ecc_sq <= wr_data[28:0];
      end
      if (in_valid && in_ready) begin
        expected_ecef.push_back(convert_position({latitude, longitude, height_mm}));
        items_in <= items_in + 1;
      end
      if (out_valid && out_ready) begin
        results_out <= results_out + 1;
        if (expected_ecef.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result x=%0d y=%0d z=%0d", x_mm, y_mm, z_mm);
        end else begin
          exp_e = expected_ecef.pop_front();
          if (exp_e.x !== x_mm || exp_e.y !== y_mm || exp_e.z !== z_mm) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                       $signed(exp_e.x), $signed(exp_e.y), $signed(exp_e.z),
                       x_mm, y_mm, z_mm);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_positions.size() == 0 && expected_ecef.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_geodetic_to_ecef_core: errors");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [32:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_positions.size() > 0 || in_valid || expected_ecef.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic add_random(input int count);
    position_t p;
    int hv;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) p.lat = 32'($urandom_range(32'h8000_0000) - 32'h4000_0000);
      else p.lat = $urandom;
      p.lon = $urandom;
      if ($urandom_range(9) < 8) hv = $urandom_range(110000000) - 10000000;
      else hv = $urandom;
      p.hgt = hv[27:0];
      pending_positions.push_back(p);
    end
  endtask

  task automatic add_position(input logic [31:0] la, input logic [31:0] lo,
                              input logic [27:0] h);
    pending_positions.push_back({la, lo, h});
  endtask

  initial begin
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] pgain;
    rst = 1'b1;
    in_valid = 1'b0;
    latitude = '0;
    longitude = '0;
    height_mm = '0;
    out_ready = 1'b0;
    wr_en = 1'b0;
    wr_index = g2e_pkg::REG_AXIS;
    wr_data = '0;
    in_taken = 1'b0;
    hold_send = 1'b0;
    steady = 1'b0;
    stall_req = 1'b0;
    stall_left = 0;
    errors = 0;
    items_in = 0;
    results_out = 0;
    quiet_cycles = 0;

    pi_val = 64'd16 * series_atan_inv(64'd5) - 64'd4 * series_atan_inv(64'd239);
    pgain = g2e_pkg::ONE_Q61;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        atan_q61_tab[i] = pi_val >> 2;
      end else begin
        t = g2e_pkg::ONE_Q61 >> i;
        sum = t;
        for (int k = 1; k < 64; k++) begin
          t = t >> (2 * i);
          if (t == 0) break;
          if (k % 2 == 1) sum = sum - t / (2 * k + 1);
          else sum = sum + t / (2 * k + 1);
        end
        atan_q61_tab[i] = sum;
      end
      pgain = pgain + (pgain >> (2 * i));
    end
    gain_val = 64'((128'd1 << 122) / {64'd0, root128({64'd0, pgain} << 61)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners
    add_position(32'd0, 32'd0, 28'd0);
    add_position(32'h4000_0000, 32'd0, 28'd0);
    add_position(32'hC000_0000, 32'h4000_0000, 28'd100000000);
    add_position(32'h8000_0000, 32'h8000_0000, -28'sd10000000);
    add_position(32'h7FFF_FFFF, 32'h7FFF_FFFF, 28'h7FF_FFFF);
    add_position(32'h2000_0000, 32'hC000_0000, 28'h800_0000);
    add_position(32'hE000_0000, 32'h2000_0000, 28'd12345);
    add_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 28'hFFF_FFFF);
    add_position(32'd1, 32'd1, 28'd1);
    add_position(32'h5000_0000, 32'hA000_0000, 28'd50000000);
    add_position(32'hB000_0000, 32'h6000_0000, 28'd0);
    add_position(32'h3FFF_FFFF, 32'hBFFF_FFFF, 28'd99999999);
    add_position(32'hC000_0001, 32'h4000_0001, -28'sd1);
    add_position(32'h1555_5555, 32'h2AAA_AAAA, 28'h555_5555);
    add_position(32'hEAAA_AAAB, 32'hD555_5556, 28'hAAA_AAAA);
    drain();

    // random items with a long receiver stall from the start of the batch
    add_random(150);
    stall_req = 1'b1;
    add_random(250);
    drain();
    stall_req = 1'b0;

    write_reg(g2e_pkg::REG_AXIS, 33'd6000000000);
    write_reg(g2e_pkg::REG_ECC, 33'd0);
    steady = 1'b1;
    add_random(130);
    drain();
    steady = 1'b0;

    write_reg(g2e_pkg::REG_AXIS, 33'd7000000000);
    write_reg(g2e_pkg::REG_ECC, 33'd429496730);
    add_position(32'h4000_0000, 32'd0, 28'd100000000);
    add_position(32'd0, 32'd0, 28'd100000000);
    add_random(130);
    drain();

    write_reg(g2e_pkg::REG_AXIS, 33'h1_FFFF_FFFF);
    write_reg(g2e_pkg::REG_ECC, 33'h1FFF_FFFF);
    add_position(32'd0, 32'd0, 28'h7FF_FFFF);
    add_position(32'd0, 32'h8000_0000, 28'h7FF_FFFF);
    add_position(32'h4000_0000, 32'd0, 28'h7FF_FFFF);
    add_random(100);
    drain();

    write_reg(g2e_pkg::REG_AXIS, 33'($urandom_range(32'd1000000000)) + 33'd6000000000);
    write_reg(g2e_pkg::REG_ECC, 33'($urandom_range(429496730)));
    add_random(120);
    drain();

    write_reg(g2e_pkg::REG_AXIS, 33'(g2e_pkg::AXIS_RESET));
    write_reg(g2e_pkg::REG_ECC, 33'(g2e_pkg::ECC_RESET));
    add_random(80);
    drain();

    $display("covered %0d positions, %0d results, over six ellipsoid settings", items_in,
             results_out);
    $display("including corner angles, height extremes, saturation and a long output stall");
    if (errors == 0) begin
      $display("tb_geodetic_to_ecef_core: clean");
    end else begin
      $display("mismatch count: %0d", errors);
      $display("tb_geodetic_to_ecef_core: errors");
    end
    $finish;
  end

endmodule
